@@ design/assert_macros.svh @@
// Assertion macros used by the checker module of the display scanner.
// Each macro expands to one labelled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables the check.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Overlapping implication built on the clocked form above.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLKD(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication built on the clocked form above.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLKD(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

@@ design/fdds_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and tables for the four-digit display scanner.
// No dependencies; fdds_bin_split, fdds_scan and the top level import this package.
package fdds_pkg;

	localparam int TICKS_PER_DIGIT = 20;
	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] CNT_DIGIT1 = CNT_W'(TICKS_PER_DIGIT);
	localparam logic [CNT_W-1:0] CNT_DIGIT2 = CNT_W'(2 * TICKS_PER_DIGIT);
	localparam logic [CNT_W-1:0] CNT_DIGIT3 = CNT_W'(3 * TICKS_PER_DIGIT);
	localparam logic [CNT_W-1:0] CNT_DIGIT4 = CNT_W'(4 * TICKS_PER_DIGIT);

	localparam int VALUE_W = 14;
	localparam int CFG_DATA_W = 14;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SOURCE_MODE   = 3'd0,
		CFG_DISPLAY_VALUE = 3'd1,
		CFG_THOUSANDS     = 3'd2,
		CFG_HUNDREDS      = 3'd3,
		CFG_TENS          = 3'd4,
		CFG_ONES          = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		POS_THOUSANDS = 2'd0,
		POS_HUNDREDS  = 2'd1,
		POS_TENS      = 2'd2,
		POS_ONES      = 2'd3
	} digit_pos_t;

	// Reciprocal multipliers, exact for every 14-bit value.
	localparam logic [13:0] DIV1000_MUL = 14'd8389;
	localparam int DIV1000_SHIFT = 23;
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam int DIV100_SHIFT = 19;
	localparam logic [15:0] DIV10_MUL = 16'd52429;
	localparam int DIV10_SHIFT = 19;

	localparam logic [4:0] DIGIT_MAX = 5'd9;

	localparam logic [6:0] SEG_TABLE [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
	};

	typedef struct packed {
		logic [4:0] thousands;
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] ones;
	} digits_t;

	typedef struct packed {
		logic    busy;
		digits_t digits;
	} split_status_t;

	typedef struct packed {
		logic fire;
		logic tick;
		logic source_mode;
	} scan_ctrl_t;

endpackage

@@ design/fdds_bin_split.sv @@
`timescale 1ns / 1ps
// Display value register and its two-stage split into decimal digits.
// Depends on fdds_pkg.
module fdds_bin_split import fdds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               value_wr,
	input  logic [VALUE_W-1:0] value_in,
	output split_status_t      status
);

	logic [VALUE_W-1:0] value_q;
	logic [1:0]         pending_q;

	logic [27:0] prod_th;
	logic [26:0] prod_100;
	logic [29:0] prod_10;

	logic [4:0]         th_s1;
	logic [7:0]         q100_s1;
	logic [10:0]        q10_s1;
	logic [VALUE_W-1:0] value_s1;

	logic [7:0]         hund_full;
	logic [10:0]        tens_full;
	logic [VALUE_W-1:0] ones_full;

	digits_t digits_s2;

	assign prod_th  = 28'(value_q) * 28'(DIV1000_MUL);
	assign prod_100 = 27'(value_q) * 27'(DIV100_MUL);
	assign prod_10  = 30'(value_q) * 30'(DIV10_MUL);

	assign hund_full = q100_s1 - (8'({th_s1, 3'b000}) + 8'({th_s1, 1'b0}));
	assign tens_full = q10_s1 - (11'({q100_s1, 3'b000}) + 11'({q100_s1, 1'b0}));
	assign ones_full = value_s1 - ({q10_s1, 3'b000} + 14'({q10_s1, 1'b0}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q   <= '0;
			pending_q <= '0;
			th_s1     <= '0;
			q100_s1   <= '0;
			q10_s1    <= '0;
			value_s1  <= '0;
			digits_s2 <= '0;
		end else begin
			if (value_wr) begin
				value_q   <= value_in;
				pending_q <= 2'd2;
			end else if (pending_q != 2'd0) begin
				pending_q <= pending_q - 2'd1;
			end
			th_s1     <= prod_th[DIV1000_SHIFT +: 5];
			q100_s1   <= prod_100[DIV100_SHIFT +: 8];
			q10_s1    <= prod_10[DIV10_SHIFT +: 11];
			value_s1  <= value_q;
			digits_s2 <= '{thousands: th_s1, hundreds: hund_full[3:0],
				tens: tens_full[3:0], ones: ones_full[3:0]};
		end
	end

	assign status = '{busy: (pending_q != 2'd0), digits: digits_s2};

endmodule

@@ design/fdds_scan.sv @@
`timescale 1ns / 1ps
// Tick counter, digit selection and segment encoding with the held result.
// Depends on fdds_pkg.
module fdds_scan import fdds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  scan_ctrl_t ctrl,
	input  digits_t    manual_digits,
	input  digits_t    split_digits,
	output logic [3:0] digit_enable,
	output logic [6:0] segments,
	output logic       refreshed
);

	logic [CNT_W-1:0] cnt_q;
	logic [3:0]       enable_q;
	logic [6:0]       segments_q;
	logic             refreshed_q;

	logic [CNT_W-1:0] cnt_inc;
	logic             hit;
	logic             wrap;
	digit_pos_t       pos;
	digits_t          src;
	logic [4:0]       digit;
	logic [6:0]       seg_new;

	assign cnt_inc = cnt_q + CNT_W'(1);
	assign src     = ctrl.source_mode ? manual_digits : split_digits;
	assign wrap    = (cnt_inc == CNT_DIGIT4);

	always_comb begin
		hit = 1'b1;
		pos = POS_ONES;
		priority if (cnt_inc == CNT_DIGIT1) begin
			pos = POS_THOUSANDS;
		end else if (cnt_inc == CNT_DIGIT2) begin
			pos = POS_HUNDREDS;
		end else if (cnt_inc == CNT_DIGIT3) begin
			pos = POS_TENS;
		end else if (wrap) begin
			pos = POS_ONES;
		end else begin
			hit = 1'b0;
		end
	end

	always_comb begin
		unique case (pos)
			POS_THOUSANDS: digit = src.thousands;
			POS_HUNDREDS:  digit = 5'(src.hundreds);
			POS_TENS:      digit = 5'(src.tens);
			POS_ONES:      digit = 5'(src.ones);
			default:       digit = 5'(src.ones);
		endcase
	end

	assign seg_new = (digit <= DIGIT_MAX) ? SEG_TABLE[digit[3:0]] : segments_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			enable_q    <= '0;
			segments_q  <= '0;
			refreshed_q <= 1'b0;
		end else if (ctrl.fire) begin
			refreshed_q <= ctrl.tick && hit;
			if (ctrl.tick) begin
				cnt_q <= wrap ? '0 : cnt_inc;
				if (hit) begin
					enable_q   <= 4'b0001 << pos;
					segments_q <= seg_new;
				end
			end
		end
	end

	assign digit_enable = enable_q;
	assign segments     = segments_q;
	assign refreshed    = refreshed_q;

endmodule

@@ design/four_digit_display_scanner_core.sv @@
`timescale 1ns / 1ps
// Top level of the four-digit display scanner: configuration registers,
// input register and handshake control. Depends on fdds_pkg, fdds_bin_split and fdds_scan.
//
// Usage: each word on the input channel carries one bit, tick. A word with tick set
// advances the scan counter; every twentieth tick moves the one-hot digit enable to
// the next position and loads that digit's segment pattern; a digit above nine keeps
// the old pattern. Every accepted word gives exactly one result word with the held
// enable, the held segments and a refreshed flag. An accepted word waits in the input
// register until it fires, and its result is then registered with out_valid. One word
// per cycle is sustained while the receiver does not stall and no split refresh runs.
// A write of the display value starts a refresh of the decimal split in fdds_bin_split;
// words already held wait in the input register during it. While the receiver stalls,
// the result register holds its word and in_stall rises once the input register is
// full, so no word is lost. Reset clears all registers, the counter, the enable (no
// digit selected) and the segments (all off); the output channel then shows no valid word.
module four_digit_display_scanner_core import fdds_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   tick,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [3:0]             digit_enable,
	output logic [6:0]             segments,
	output logic                   refreshed,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic    source_mode_q;
	digits_t manual_q;
	logic    valid_s1;
	logic    tick_s1;
	logic    out_valid_q;
	logic    fire;
	logic    value_wr;

	split_status_t split_status;
	scan_ctrl_t    scan_ctrl;

	assign value_wr  = cfg_write && (cfg_index == CFG_DISPLAY_VALUE);
	assign fire      = valid_s1 && !split_status.busy && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !fire;
	assign scan_ctrl = '{fire: fire, tick: tick_s1, source_mode: source_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_mode_q <= 1'b0;
			manual_q      <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SOURCE_MODE:   source_mode_q      <= cfg_data[0];
				CFG_DISPLAY_VALUE: source_mode_q      <= source_mode_q;
				CFG_THOUSANDS:     manual_q.thousands <= 5'(cfg_data[3:0]);
				CFG_HUNDREDS:      manual_q.hundreds  <= cfg_data[3:0];
				CFG_TENS:          manual_q.tens      <= cfg_data[3:0];
				CFG_ONES:          manual_q.ones      <= cfg_data[3:0];
				default:           manual_q           <= manual_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			tick_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
				tick_s1  <= tick;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	fdds_bin_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.value_wr (value_wr),
		.value_in (cfg_data[VALUE_W-1:0]),
		.status   (split_status)
	);

	fdds_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (scan_ctrl),
		.manual_digits (manual_q),
		.split_digits  (split_status.digits),
		.digit_enable  (digit_enable),
		.segments      (segments),
		.refreshed     (refreshed)
	);

	assign out_valid = out_valid_q;

endmodule

@@ design/fdds_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the display scanner and its bind to the top level.
// Depends on assert_macros.svh and four_digit_display_scanner_core.
`include "assert_macros.svh"

module fdds_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] digit_enable,
	input logic [6:0] segments,
	input logic       refreshed
);

	`ASSERT_IMPLIES(a_enable_onehot0, clk, arst_n, out_valid, $onehot0(digit_enable), "digit enable selects more than one digit")
	`ASSERT_IMPLIES(a_refresh_selects, clk, arst_n, out_valid && refreshed, $onehot(digit_enable), "refreshed word without a selected digit")
	`ASSERT_IMPLIES(a_dark_when_unselected, clk, arst_n, digit_enable == 4'b0000, segments == 7'b0000000, "segments lit before any digit was selected")
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(digit_enable) && $stable(segments) && $stable(refreshed), "stalled result word changed")

endmodule

bind four_digit_display_scanner_core fdds_checker u_fdds_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.digit_enable (digit_enable),
	.segments     (segments),
	.refreshed    (refreshed)
);
